// ----- design/tlt_pkg.sv -----
// ----------------------------------------------------------------------------
// tlt_pkg: shared constants and types for the thick-line quad expander
// Fixed field widths, vertex sequencing and corner lookup.
// ----------------------------------------------------------------------------
package tlt_pkg;

    // fixed field widths
    localparam int W_BITS     = 12;  // line width field
    localparam int COLOR_BITS = 32;
    localparam int ALPHA_BITS = 8;
    localparam int MAG_BITS   = 12;  // offset magnitude search steps
    localparam int NUM_VERTS  = 6;
    localparam int CNT_BITS   = 3;

    typedef logic [CNT_BITS-1:0] t_vcnt;
    localparam t_vcnt LAST_VERT = t_vcnt'(NUM_VERTS - 1);

    typedef enum logic [1:0] {
        C_P0 = 2'd0,
        C_P1 = 2'd1,
        C_P2 = 2'd2,
        C_P3 = 2'd3
    } t_corner;

    // triangle order p0,p1,p2,p0,p2,p3
    function automatic t_corner corner_of(input t_vcnt cnt);
        t_corner c;
        case (cnt)
            3'd0: c = C_P0;
            3'd1: c = C_P1;
            3'd2: c = C_P2;
            3'd3: c = C_P0;
            3'd4: c = C_P2;
            3'd5: c = C_P3;
            default: c = C_P0;
        endcase
        return c;
    endfunction

endpackage

// ----- design/tlt_ifs.sv -----
// ----------------------------------------------------------------------------
// tlt_ifs: valid/ready channels for segments and vertices
// One beat carries one segment or one vertex.
// ----------------------------------------------------------------------------
interface tlt_seg_if import tlt_pkg::*; #(parameter int CB = 16) ();
    logic                    valid;
    logic                    ready;
    logic signed [CB-1:0]    start_x;
    logic signed [CB-1:0]    start_y;
    logic signed [CB-1:0]    end_x;
    logic signed [CB-1:0]    end_y;
    logic [W_BITS-1:0]       line_width;
    logic [COLOR_BITS-1:0]   color_rgba;

    modport source (output valid, start_x, start_y, end_x, end_y, line_width, color_rgba,
                    input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, line_width, color_rgba,
                    output ready);
endinterface

interface tlt_vtx_if import tlt_pkg::*; #(parameter int CB = 16) ();
    logic                    valid;
    logic                    ready;
    logic signed [CB-1:0]    vertex_x;
    logic signed [CB-1:0]    vertex_y;
    logic [COLOR_BITS-1:0]   vertex_color;
    logic                    last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_color, last_vertex,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_color, last_vertex,
                    output ready);
endinterface

// ----- design/thick_line_to_triangles.sv -----
// ----------------------------------------------------------------------------
// thick_line_to_triangles: line segment to thick-line quad expander
// Emits six vertices (two triangles) per accepted segment of nonzero length, alpha and width.
// ----------------------------------------------------------------------------
// A segment beat is taken every cycle while the pipeline moves; each kept
// segment yields six vertex beats, one per cycle while the output is ready,
// so sustained throughput is set by the single-vertex output sequencer.
// Segments with zero length, zero alpha or zero width produce no beats and
// cost only one slot in the pipe. The path from segment beat to first vertex
// valid runs through 3 prep stages, one stage per offset bit (12), a corner
// stage and the output register.
// ----------------------------------------------------------------------------
module thick_line_to_triangles import tlt_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlt_seg_if.sink    i_seg,
    tlt_vtx_if.source  o_vtx
);

    localparam int CB = COORD_BITS;
    localparam int RW = 2*CB + 2*W_BITS;

    logic                  adv;
    logic                  pr_valid, pr_dy_pos, pr_dx_neg;
    logic signed [CB-1:0]  pr_x1, pr_y1, pr_x2, pr_y2;
    logic [COLOR_BITS-1:0] pr_col;
    logic [2*CB:0]         pr_d;
    logic [RW-1:0]         pr_rhs_x, pr_rhs_y;

    logic                  se_valid, se_dy_pos, se_dx_neg;
    logic signed [CB-1:0]  se_x1, se_y1, se_x2, se_y2;
    logic [COLOR_BITS-1:0] se_col;
    logic [MAG_BITS-1:0]   se_mx, se_my;

    tlt_prep #(.CB(CB)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_seg    (i_seg),
        .o_valid  (pr_valid),
        .o_x1     (pr_x1),
        .o_y1     (pr_y1),
        .o_x2     (pr_x2),
        .o_y2     (pr_y2),
        .o_col    (pr_col),
        .o_dy_pos (pr_dy_pos),
        .o_dx_neg (pr_dx_neg),
        .o_d      (pr_d),
        .o_rhs_x  (pr_rhs_x),
        .o_rhs_y  (pr_rhs_y)
    );

    tlt_search #(.CB(CB)) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (pr_valid),
        .i_x1     (pr_x1),
        .i_y1     (pr_y1),
        .i_x2     (pr_x2),
        .i_y2     (pr_y2),
        .i_col    (pr_col),
        .i_dy_pos (pr_dy_pos),
        .i_dx_neg (pr_dx_neg),
        .i_d      (pr_d),
        .i_rhs_x  (pr_rhs_x),
        .i_rhs_y  (pr_rhs_y),
        .o_valid  (se_valid),
        .o_x1     (se_x1),
        .o_y1     (se_y1),
        .o_x2     (se_x2),
        .o_y2     (se_y2),
        .o_col    (se_col),
        .o_dy_pos (se_dy_pos),
        .o_dx_neg (se_dx_neg),
        .o_mx     (se_mx),
        .o_my     (se_my)
    );

    tlt_emit #(.CB(CB)) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (se_valid),
        .i_x1     (se_x1),
        .i_y1     (se_y1),
        .i_x2     (se_x2),
        .i_y2     (se_y2),
        .i_col    (se_col),
        .i_dy_pos (se_dy_pos),
        .i_dx_neg (se_dx_neg),
        .i_mx     (se_mx),
        .i_my     (se_my),
        .o_adv    (adv),
        .o_vtx    (o_vtx)
    );

endmodule

// ----- design/tlt_prep.sv -----
// ----------------------------------------------------------------------------
// tlt_prep: front end of the expander
// Deltas and reject test, then squares, then length^2 and search bounds.
// ----------------------------------------------------------------------------
module tlt_prep import tlt_pkg::*; #(
    parameter int CB = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    tlt_seg_if.sink                 i_seg,
    output logic                    o_valid,
    output logic signed [CB-1:0]    o_x1,
    output logic signed [CB-1:0]    o_y1,
    output logic signed [CB-1:0]    o_x2,
    output logic signed [CB-1:0]    o_y2,
    output logic [COLOR_BITS-1:0]   o_col,
    output logic                    o_dy_pos,
    output logic                    o_dx_neg,
    output logic [2*CB:0]           o_d,
    output logic [2*CB+2*W_BITS-1:0] o_rhs_x,
    output logic [2*CB+2*W_BITS-1:0] o_rhs_y
);

    localparam int SQ = 2*CB;
    localparam int RW = 2*CB + 2*W_BITS;

    logic signed [CB:0] dx, dy;
    logic [CB-1:0]      adx, ady;
    logic               reject;

    assign i_seg.ready = i_en;

    // deltas, magnitudes and reject
    always_comb begin
        dx = {i_seg.end_x[CB-1], i_seg.end_x} - {i_seg.start_x[CB-1], i_seg.start_x};
        dy = {i_seg.end_y[CB-1], i_seg.end_y} - {i_seg.start_y[CB-1], i_seg.start_y};
        adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
        ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
        reject = (dx == '0 && dy == '0) || (i_seg.color_rgba[ALPHA_BITS-1:0] == '0)
                 || (i_seg.line_width == '0);
    end

    // stage 0 registers
    logic                  r0_valid;
    logic signed [CB-1:0]  r0_x1, r0_y1, r0_x2, r0_y2;
    logic [COLOR_BITS-1:0] r0_col;
    logic [W_BITS-1:0]     r0_w;
    logic [CB-1:0]         r0_adx, r0_ady;
    logic                  r0_dy_pos, r0_dx_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_seg.valid && !reject;
        end
        if (i_en) begin
            r0_x1     <= i_seg.start_x;
            r0_y1     <= i_seg.start_y;
            r0_x2     <= i_seg.end_x;
            r0_y2     <= i_seg.end_y;
            r0_col    <= i_seg.color_rgba;
            r0_w      <= i_seg.line_width;
            r0_adx    <= adx;
            r0_ady    <= ady;
            r0_dy_pos <= !dy[CB] && (dy != '0);
            r0_dx_neg <= dx[CB];
        end
    end

    // stage 1: squares
    logic                  r1_valid;
    logic signed [CB-1:0]  r1_x1, r1_y1, r1_x2, r1_y2;
    logic [COLOR_BITS-1:0] r1_col;
    logic [SQ-1:0]         r1_adx2, r1_ady2;
    logic [2*W_BITS-1:0]   r1_w2;
    logic                  r1_dy_pos, r1_dx_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= r0_valid;
        end
        if (i_en) begin
            r1_x1     <= r0_x1;
            r1_y1     <= r0_y1;
            r1_x2     <= r0_x2;
            r1_y2     <= r0_y2;
            r1_col    <= r0_col;
            r1_adx2   <= SQ'(r0_adx) * SQ'(r0_adx);
            r1_ady2   <= SQ'(r0_ady) * SQ'(r0_ady);
            r1_w2     <= (2*W_BITS)'(r0_w) * (2*W_BITS)'(r0_w);
            r1_dy_pos <= r0_dy_pos;
            r1_dx_neg <= r0_dx_neg;
        end
    end

    // stage 2: length squared and right-hand bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r1_valid;
        end
        if (i_en) begin
            o_x1     <= r1_x1;
            o_y1     <= r1_y1;
            o_x2     <= r1_x2;
            o_y2     <= r1_y2;
            o_col    <= r1_col;
            o_d      <= (SQ+1)'(r1_adx2) + (SQ+1)'(r1_ady2);
            o_rhs_x  <= RW'(r1_adx2) * RW'(r1_w2);
            o_rhs_y  <= RW'(r1_ady2) * RW'(r1_w2);
            o_dy_pos <= r1_dy_pos;
            o_dx_neg <= r1_dx_neg;
        end
    end

endmodule

// ----- design/tlt_search.sv -----
// ----------------------------------------------------------------------------
// tlt_search: offset magnitude search, one bit per stage, two lanes
// Finds the largest m with d*(2m-1)^2 <= a^2*w^2, keeping d*u^2 and d*u
// (u = 2m) so each stage needs only shifted adds and one compare per lane.
// ----------------------------------------------------------------------------
module tlt_search import tlt_pkg::*; #(
    parameter int CB = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [CB-1:0]     i_x1,
    input  logic signed [CB-1:0]     i_y1,
    input  logic signed [CB-1:0]     i_x2,
    input  logic signed [CB-1:0]     i_y2,
    input  logic [COLOR_BITS-1:0]    i_col,
    input  logic                     i_dy_pos,
    input  logic                     i_dx_neg,
    input  logic [2*CB:0]            i_d,
    input  logic [2*CB+2*W_BITS-1:0] i_rhs_x,
    input  logic [2*CB+2*W_BITS-1:0] i_rhs_y,
    output logic                     o_valid,
    output logic signed [CB-1:0]     o_x1,
    output logic signed [CB-1:0]     o_y1,
    output logic signed [CB-1:0]     o_x2,
    output logic signed [CB-1:0]     o_y2,
    output logic [COLOR_BITS-1:0]    o_col,
    output logic                     o_dy_pos,
    output logic                     o_dx_neg,
    output logic [MAG_BITS-1:0]      o_mx,
    output logic [MAG_BITS-1:0]      o_my
);

    localparam int DW = 2*CB + 1;
    localparam int RW = 2*CB + 2*W_BITS;
    localparam int QW = DW + MAG_BITS + 2;
    localparam int PW = 2*CB + 2*MAG_BITS + 4;

    // per-stage registers, stage i+1 is the output of search step i
    logic                  r_valid  [1:MAG_BITS];
    logic signed [CB-1:0]  r_x1     [1:MAG_BITS];
    logic signed [CB-1:0]  r_y1     [1:MAG_BITS];
    logic signed [CB-1:0]  r_x2     [1:MAG_BITS];
    logic signed [CB-1:0]  r_y2     [1:MAG_BITS];
    logic [COLOR_BITS-1:0] r_col    [1:MAG_BITS];
    logic                  r_dy_pos [1:MAG_BITS];
    logic                  r_dx_neg [1:MAG_BITS];
    logic [DW-1:0]         r_d      [1:MAG_BITS];
    logic [RW-1:0]         r_rhs_x  [1:MAG_BITS];
    logic [RW-1:0]         r_rhs_y  [1:MAG_BITS];
    logic [MAG_BITS-1:0]   r_mx     [1:MAG_BITS];
    logic [MAG_BITS-1:0]   r_my     [1:MAG_BITS];
    logic [PW-1:0]         r_px     [1:MAG_BITS];
    logic [PW-1:0]         r_py     [1:MAG_BITS];
    logic [QW-1:0]         r_qx     [1:MAG_BITS];
    logic [QW-1:0]         r_qy     [1:MAG_BITS];

    for (genvar i = 0; i < MAG_BITS; i++) begin : g_step
        localparam int K = MAG_BITS - 1 - i;

        logic                  p_valid, p_dy_pos, p_dx_neg;
        logic signed [CB-1:0]  p_x1, p_y1, p_x2, p_y2;
        logic [COLOR_BITS-1:0] p_col;
        logic [DW-1:0]         p_d;
        logic [RW-1:0]         p_rhs_x, p_rhs_y;
        logic [MAG_BITS-1:0]   p_mx, p_my;
        logic [PW-1:0]         p_px, p_py;
        logic [QW-1:0]         p_qx, p_qy;
        logic [PW-1:0]         dd, tx, ty;
        logic                  ok_x, ok_y;

        // previous stage or pipeline input
        if (i == 0) begin : g_first
            always_comb begin
                p_valid = i_valid;  p_dy_pos = i_dy_pos; p_dx_neg = i_dx_neg;
                p_x1 = i_x1;  p_y1 = i_y1;  p_x2 = i_x2;  p_y2 = i_y2;
                p_col = i_col; p_d = i_d; p_rhs_x = i_rhs_x; p_rhs_y = i_rhs_y;
                p_mx = '0; p_my = '0; p_px = '0; p_py = '0; p_qx = '0; p_qy = '0;
            end
        end else begin : g_next
            always_comb begin
                p_valid = r_valid[i];  p_dy_pos = r_dy_pos[i]; p_dx_neg = r_dx_neg[i];
                p_x1 = r_x1[i];  p_y1 = r_y1[i];  p_x2 = r_x2[i];  p_y2 = r_y2[i];
                p_col = r_col[i]; p_d = r_d[i]; p_rhs_x = r_rhs_x[i]; p_rhs_y = r_rhs_y[i];
                p_mx = r_mx[i]; p_my = r_my[i]; p_px = r_px[i]; p_py = r_py[i];
                p_qx = r_qx[i]; p_qy = r_qy[i];
            end
        end

        // candidate d*(u+2s-1)^2 with s = 2^K
        always_comb begin
            dd = PW'(p_d);
            tx = p_px + (PW'(p_qx) << (K+2)) - (PW'(p_qx) << 1)
                 + (dd << (2*K+2)) - (dd << (K+2)) + dd;
            ty = p_py + (PW'(p_qy) << (K+2)) - (PW'(p_qy) << 1)
                 + (dd << (2*K+2)) - (dd << (K+2)) + dd;
            ok_x = tx <= PW'(p_rhs_x);
            ok_y = ty <= PW'(p_rhs_y);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= p_valid;
            end
            if (i_en) begin
                r_x1[i+1]     <= p_x1;
                r_y1[i+1]     <= p_y1;
                r_x2[i+1]     <= p_x2;
                r_y2[i+1]     <= p_y2;
                r_col[i+1]    <= p_col;
                r_dy_pos[i+1] <= p_dy_pos;
                r_dx_neg[i+1] <= p_dx_neg;
                r_d[i+1]      <= p_d;
                r_rhs_x[i+1]  <= p_rhs_x;
                r_rhs_y[i+1]  <= p_rhs_y;
                // accept step: u += 2s
                r_mx[i+1] <= ok_x ? (p_mx | (MAG_BITS'(1) << K)) : p_mx;
                r_px[i+1] <= ok_x ? (p_px + (PW'(p_qx) << (K+2)) + (dd << (2*K+2))) : p_px;
                r_qx[i+1] <= ok_x ? (p_qx + (QW'(p_d) << (K+1))) : p_qx;
                r_my[i+1] <= ok_y ? (p_my | (MAG_BITS'(1) << K)) : p_my;
                r_py[i+1] <= ok_y ? (p_py + (PW'(p_qy) << (K+2)) + (dd << (2*K+2))) : p_py;
                r_qy[i+1] <= ok_y ? (p_qy + (QW'(p_d) << (K+1))) : p_qy;
            end
        end
    end

    assign o_valid  = r_valid[MAG_BITS];
    assign o_x1     = r_x1[MAG_BITS];
    assign o_y1     = r_y1[MAG_BITS];
    assign o_x2     = r_x2[MAG_BITS];
    assign o_y2     = r_y2[MAG_BITS];
    assign o_col    = r_col[MAG_BITS];
    assign o_dy_pos = r_dy_pos[MAG_BITS];
    assign o_dx_neg = r_dx_neg[MAG_BITS];
    assign o_mx     = r_mx[MAG_BITS];
    assign o_my     = r_my[MAG_BITS];

endmodule

// ----- design/tlt_emit.sv -----
// ----------------------------------------------------------------------------
// tlt_emit: corner build and vertex sequencer
// Saturated quad corners, then six vertex beats per segment.
// ----------------------------------------------------------------------------
module tlt_emit import tlt_pkg::*; #(
    parameter int CB = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [CB-1:0]  i_x1,
    input  logic signed [CB-1:0]  i_y1,
    input  logic signed [CB-1:0]  i_x2,
    input  logic signed [CB-1:0]  i_y2,
    input  logic [COLOR_BITS-1:0] i_col,
    input  logic                  i_dy_pos,
    input  logic                  i_dx_neg,
    input  logic [MAG_BITS-1:0]   i_mx,
    input  logic [MAG_BITS-1:0]   i_my,
    output logic                  o_adv,
    tlt_vtx_if.source             o_vtx
);

    localparam int SW = CB + MAG_BITS + 2;
    localparam logic signed [SW-1:0] VMAX = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN = ~VMAX;

    function automatic logic signed [CB-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
        return c[CB-1:0];
    endfunction

    logic signed [SW-1:0] nx, ny, x1e, y1e, x2e, y2e;
    logic                 take, em_load;

    // signed offsets
    always_comb begin
        nx  = i_dy_pos ? -SW'(i_my) : SW'(i_my);
        ny  = i_dx_neg ? -SW'(i_mx) : SW'(i_mx);
        x1e = SW'(i_x1);
        y1e = SW'(i_y1);
        x2e = SW'(i_x2);
        y2e = SW'(i_y2);
    end

    // corner stage
    logic                  r_vs_valid;
    logic signed [CB-1:0]  r_vs_x [4];
    logic signed [CB-1:0]  r_vs_y [4];
    logic [COLOR_BITS-1:0] r_vs_col;

    // sequencer holding registers
    logic                  r_em_valid;
    logic signed [CB-1:0]  r_em_x [4];
    logic signed [CB-1:0]  r_em_y [4];
    logic [COLOR_BITS-1:0] r_em_col;
    logic [CNT_BITS-1:0]   r_cnt;

    assign take    = o_vtx.valid && o_vtx.ready;
    assign em_load = !r_em_valid || (take && r_cnt == LAST_VERT);
    assign o_adv   = !r_vs_valid || em_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs_valid <= 1'b0;
        end else if (o_adv) begin
            r_vs_valid <= i_valid;
        end
        if (o_adv) begin
            r_vs_x[0] <= sat(x1e + nx);  r_vs_y[0] <= sat(y1e + ny);
            r_vs_x[1] <= sat(x2e + nx);  r_vs_y[1] <= sat(y2e + ny);
            r_vs_x[2] <= sat(x2e - nx);  r_vs_y[2] <= sat(y2e - ny);
            r_vs_x[3] <= sat(x1e - nx);  r_vs_y[3] <= sat(y1e - ny);
            r_vs_col  <= i_col;
        end
    end

    // one vertex beat per cycle while the output is ready, six per segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid <= 1'b0;
            r_cnt      <= '0;
        end else if (em_load) begin
            r_em_valid <= r_vs_valid;
            r_cnt      <= '0;
        end else if (take) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (em_load) begin
            r_em_x   <= r_vs_x;
            r_em_y   <= r_vs_y;
            r_em_col <= r_vs_col;
        end
    end

    // corner select
    always_comb begin
        case (corner_of(r_cnt))
            C_P0:    begin o_vtx.vertex_x = r_em_x[0]; o_vtx.vertex_y = r_em_y[0]; end
            C_P1:    begin o_vtx.vertex_x = r_em_x[1]; o_vtx.vertex_y = r_em_y[1]; end
            C_P2:    begin o_vtx.vertex_x = r_em_x[2]; o_vtx.vertex_y = r_em_y[2]; end
            C_P3:    begin o_vtx.vertex_x = r_em_x[3]; o_vtx.vertex_y = r_em_y[3]; end
            default: begin o_vtx.vertex_x = r_em_x[0]; o_vtx.vertex_y = r_em_y[0]; end
        endcase
    end

    assign o_vtx.valid        = r_em_valid;
    assign o_vtx.vertex_color = r_em_col;
    assign o_vtx.last_vertex  = (r_cnt == LAST_VERT);

endmodule
